// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes and the types of the fixed-width item fields.
// ----------------------------------------------------------------------------
package deq_pkg;

    typedef logic [2:0]         t_cmd;
    typedef logic [1:0]         t_status;
    typedef logic signed [31:0] t_word;
    typedef logic [9:0]         t_position;
    typedef logic [10:0]        t_count;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_READ_FRONT = 3'd4;
    localparam t_cmd CMD_READ_BACK  = 3'd5;
    localparam t_cmd CMD_READ_INDEX = 3'd6;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue core
// Fixed-capacity deque of signed words held in a circular RAM.
// ----------------------------------------------------------------------------
// The input channel carries one command per item: push at the front or
// back, pop the front or back, read the front or back, or read the entry
// at a position counted from the front. The output channel returns one
// item per command with the read data, a status code and the new count.
// Push, pop and error commands show their result in the cycle after acceptance.
// Read commands pass through the RAM read register and the read state before
// the result reaches the output register. Pushes and pops can be accepted in
// every cycle while the output is not stalled; a read blocks the input in S_READ.
// A push when full, a pop or read when empty, and an index beyond the
// stored entries are flagged in the status and leave the state unchanged.
// Reset empties the queue and clears the output valid flag; RAM contents
// are not cleared. When the receiver stalls, the result is held in the output
// register and a new item is accepted only once that result is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  deq_pkg::t_cmd       i_cmd,
    input  deq_pkg::t_word      i_value,
    input  deq_pkg::t_position  i_position,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output deq_pkg::t_word      o_data,
    output deq_pkg::t_status    o_status,
    output deq_pkg::t_count     o_count
);

    import deq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((PW > 10) ? PW : 10) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic            r_state, n_state;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_occ, n_occ;
    logic            r_out_valid, n_out_valid;
    t_word           r_out_data, n_out_data;
    t_status         r_out_status, n_out_status;
    t_count          r_out_count, n_out_count;

    logic                  w_accept;
    logic                  w_empty;
    logic                  w_full;
    logic [PW-1:0]         w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic [SW-1:0]         w_sum, w_idx_full;
    logic [PW-1:0]         w_idx;
    logic                  w_range;
    logic [63:0]           w_value_ext;
    logic [63:0]           w_rd_ext;
    logic [31:0]           w_occ_ext;
    logic                  ram_en, ram_we;
    logic [PW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_empty = (r_occ == '0);
    assign w_full  = (r_occ == CW'(CAPACITY));

    assign w_head_inc = (r_head == PW'(CAPACITY - 1)) ? '0 : r_head + PW'(1);
    assign w_head_dec = (r_head == '0) ? PW'(CAPACITY - 1) : r_head - PW'(1);
    assign w_tail_inc = (r_tail == PW'(CAPACITY - 1)) ? '0 : r_tail + PW'(1);
    assign w_tail_dec = (r_tail == '0) ? PW'(CAPACITY - 1) : r_tail - PW'(1);

    assign w_sum      = SW'(r_head) + SW'(i_position);
    assign w_idx_full = (w_sum >= SW'(CAPACITY)) ? w_sum - SW'(CAPACITY) : w_sum;
    assign w_idx      = w_idx_full[PW-1:0];
    assign w_range    = SW'(i_position) >= SW'(r_occ);

    assign w_value_ext = {{32{i_value[31]}}, i_value};
    assign w_rd_ext    = 64'(ram_rdata);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = r_head;
        w_occ_ext    = 32'(r_occ);

        if (r_state == S_READ) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out_data  = w_rd_ext[31:0];
        end else if (w_accept) begin
            n_out_valid  = 1'b1;
            n_out_data   = '0;
            n_out_status = ST_OK;
            case (i_cmd)
                CMD_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_head   = w_head_dec;
                        n_occ    = r_occ + CW'(1);
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = w_head_dec;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_tail   = w_tail_inc;
                        n_occ    = r_occ + CW'(1);
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = r_tail;
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_head = w_head_inc;
                        n_occ  = r_occ - CW'(1);
                    end
                end
                CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_tail = w_tail_dec;
                        n_occ  = r_occ - CW'(1);
                    end
                end
                CMD_READ_FRONT: begin
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        ram_en      = 1'b1;
                        ram_addr    = r_head;
                        n_state     = S_READ;
                        n_out_valid = 1'b0;
                    end
                end
                CMD_READ_BACK: begin
                    if (w_empty) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        ram_en      = 1'b1;
                        ram_addr    = w_tail_dec;
                        n_state     = S_READ;
                        n_out_valid = 1'b0;
                    end
                end
                CMD_READ_INDEX: begin
                    if (w_range) begin
                        n_out_status = ST_RANGE;
                    end else begin
                        ram_en      = 1'b1;
                        ram_addr    = w_idx;
                        n_state     = S_READ;
                        n_out_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            w_occ_ext   = 32'(n_occ);
            n_out_count = w_occ_ext[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (w_value_ext[DATA_WIDTH-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the queue core, attached by a bind statement.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input deq_pkg::t_word     o_data,
    input deq_pkg::t_status   o_status,
    input deq_pkg::t_count    o_count
);

    import deq_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data)
            && $stable(o_status) && $stable(o_count))
        else $error("Stalled output item changed.");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input accepted while the output is stalled.");

    a_error_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_data == '0)
        else $error("Nonzero data on an error result.");

    a_empty_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_count == '0)
        else $error("Empty status with a nonzero count.");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_data      (o_data),
    .o_status    (o_status),
    .o_count     (o_count)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and read commands through the input channel and checks
// every result against a local deque shadow, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;

    import deq_pkg::*;

    localparam int   DEPTH      = 1024;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam t_cmd CMD_UNUSED = 3'd7;

    typedef struct {
        t_cmd      cmd;
        t_word     value;
        t_position position;
        bit        wait_idle;
    } t_command;

    typedef struct {
        t_word   data;
        t_status status;
        t_count  count;
    } t_result;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      out_ready  = 1'b0;
    t_cmd      cmd_q      = '0;
    t_word     value_q    = '0;
    t_position position_q = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_word     o_data;
    t_status   o_status;
    t_count    o_count;

    double_ended_queue_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (cmd_q),
        .i_value     (value_q),
        .i_position  (position_q),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    t_command  pending_cmds[$];
    t_result   expected_results[$];

    t_word     shadow_store [DEPTH];
    logic [9:0] shadow_front = '0;
    logic [9:0] shadow_back  = '0;
    t_count    shadow_occ   = '0;

    int        plan_count    = 0;
    int        error_count   = 0;
    int        accepted_cnt  = 0;
    int        sent_cnt      = 0;
    int        cycle_cnt     = 0;
    logic      in_fire       = 1'b0;
    int        gap_left      = 0;
    int        stall_left    = 0;
    int        hold_left     = 0;
    bit        hold_done     = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    task automatic deque_apply(input t_command c, output t_result r);
        logic [9:0] slot;
        r.data   = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_PUSH_FRONT: begin
                if (shadow_occ == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_store[shadow_front] = c.value;
                    shadow_occ = shadow_occ + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (shadow_occ == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[shadow_back] = c.value;
                    shadow_back = shadow_back + 1'b1;
                    shadow_occ = shadow_occ + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_occ == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_front = shadow_front + 1'b1;
                    shadow_occ = shadow_occ - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_occ == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_back = shadow_back - 1'b1;
                    shadow_occ = shadow_occ - 1'b1;
                end
            end
            CMD_READ_FRONT: begin
                if (shadow_occ == 0) r.status = ST_EMPTY;
                else r.data = shadow_store[shadow_front];
            end
            CMD_READ_BACK: begin
                slot = shadow_back - 1'b1;
                if (shadow_occ == 0) r.status = ST_EMPTY;
                else r.data = shadow_store[slot];
            end
            CMD_READ_INDEX: begin
                slot = shadow_front + c.position;
                if (c.position >= shadow_occ) r.status = ST_RANGE;
                else r.data = shadow_store[slot];
            end
            default: begin
            end
        endcase
        r.count = shadow_occ;
    endtask

    task automatic queue_command(input t_cmd cmd, input t_word value, input t_position pos,
                                 input bit wait_idle);
        t_command c;
        c.cmd       = cmd;
        c.value     = value;
        c.position  = pos;
        c.wait_idle = wait_idle;
        pending_cmds.insert(pending_cmds.size(), c);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
            CMD_POP_FRONT, CMD_POP_BACK:   if (plan_count > 0) plan_count--;
            default: begin
            end
        endcase
    endtask

    function automatic t_word pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return 32'sh7FFF_FFFF;
        if (sel < 6) return 32'sh8000_0000;
        if (sel < 8) return 32'sd0;
        if (sel < 10) return -32'sd1;
        return $urandom;
    endfunction

    task automatic queue_random(input int push_w, input int pop_w, input bit wait_idle);
        int        sel;
        t_cmd      cmd;
        t_position pos;
        sel = $urandom_range(99);
        pos = $urandom_range(DEPTH - 1);
        if (sel < push_w) begin
            cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else if (sel < push_w + pop_w) begin
            cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end else if (sel < 98) begin
            case ($urandom_range(2))
                0:       cmd = CMD_READ_FRONT;
                1:       cmd = CMD_READ_BACK;
                default: cmd = CMD_READ_INDEX;
            endcase
            if (cmd == CMD_READ_INDEX) begin
                if (plan_count > 0 && $urandom_range(99) < 80)
                    pos = $urandom_range(plan_count - 1);
                else if (plan_count < DEPTH)
                    pos = $urandom_range(DEPTH - 1, plan_count);
            end
        end else begin
            cmd = CMD_UNUSED;
        end
        queue_command(cmd, pick_word(), pos, wait_idle);
    endtask

    function automatic int pick_gap(input int mode);
        int sel;
        sel = $urandom_range(99);
        if (mode == 0) return 0;
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(3, 1);
        return (mode == 2) ? $urandom_range(40, 5) : $urandom_range(6, 2);
    endfunction

    always @(negedge i_clk) begin
        t_command c;
        bit       busy;
        if (i_rst_n) begin
            busy = in_valid && !in_fire;
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 &&
                             !(pending_cmds[0].wait_idle && expected_results.size() > 0)) begin
                    c = pending_cmds[0];
                    pending_cmds.delete(0);
                    cmd_q      <= c.cmd;
                    value_q    <= c.value;
                    position_q <= c.position;
                    in_valid   <= 1'b1;
                    sent_cnt++;
                    gap_left = pick_gap((sent_cnt / 150) % 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int mode;
        if (i_rst_n) begin
            mode = (cycle_cnt / 1000) % 3;
            if (!hold_done && accepted_cnt >= 500) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (mode != 0 && $urandom_range(99) < 30) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 5) :
                                                        $urandom_range(2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_command c;
        t_result  r;
        t_result  want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && o_in_ready;
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count < 200)
                        $display("%0t: unexpected result data=%0d status=%0d count=%0d",
                                 $time, o_data, o_status, o_count);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (want.data !== o_data || want.status !== o_status ||
                        want.count !== o_count) begin
                        error_count++;
                        if (error_count < 200) begin
                            if (want.data !== o_data)
                                $display("%0t: data mismatch expected %0d actual %0d",
                                         $time, want.data, o_data);
                            if (want.status !== o_status)
                                $display("%0t: status mismatch expected %0d actual %0d",
                                         $time, want.status, o_status);
                            if (want.count !== o_count)
                                $display("%0t: count mismatch expected %0d actual %0d",
                                         $time, want.count, o_count);
                        end
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                c.cmd       = cmd_q;
                c.value     = value_q;
                c.position  = position_q;
                c.wait_idle = 1'b0;
                deque_apply(c, r);
                expected_results.insert(expected_results.size(), r);
                accepted_cnt++;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int n;
        // Empty queue: every pop and read is flagged.
        queue_command(CMD_READ_FRONT, 32'sd5, 10'd0, 1'b0);
        queue_command(CMD_READ_BACK, 32'sd5, 10'd0, 1'b0);
        queue_command(CMD_POP_FRONT, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_POP_BACK, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd1023, 1'b0);
        queue_command(CMD_UNUSED, -32'sd1, 10'd1023, 1'b0);
        // Extreme words at both ends; the first front push wraps the head.
        queue_command(CMD_PUSH_BACK, 32'sh7FFF_FFFF, 10'd0, 1'b0);
        queue_command(CMD_PUSH_FRONT, 32'sh8000_0000, 10'd1023, 1'b0);
        queue_command(CMD_PUSH_BACK, -32'sd1, 10'd512, 1'b0);
        queue_command(CMD_PUSH_FRONT, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_FRONT, 32'sd0, 10'd0, 1'b1);
        queue_command(CMD_READ_BACK, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd3, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd4, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd1023, 1'b0);
        queue_command(CMD_UNUSED, 32'sd17, 10'd2, 1'b0);
        queue_command(CMD_POP_FRONT, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_POP_BACK, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_INDEX, 32'sd0, 10'd1, 1'b0);
        queue_command(CMD_POP_BACK, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_POP_FRONT, 32'sd0, 10'd0, 1'b0);
        queue_command(CMD_READ_BACK, 32'sd0, 10'd0, 1'b0);

        for (n = 0; n < 60; n++)
            queue_random(35, 25, n == 40);
        while (plan_count < DEPTH)
            queue_random(95, 0, 1'b0);
        for (n = 0; n < 30; n++)
            queue_random(50, 0, n == 0);
        for (n = 0; n < 100; n++)
            queue_random(30, 40, n == 50);

        while (pending_cmds.size() > 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
